>>> hw/rtl/vtpd_pkg.sv
// Shared types and constants for the vertex transform and perspective divide block.
package vtpd_pkg;

  localparam int unsigned COORD_W   = 32;  // width of a coordinate / matrix element
  localparam int unsigned PROD_W    = 64;  // 32x32 signed product
  localparam int unsigned SUM_W     = 66;  // exact signed sum of three products and translation
  localparam int unsigned MAG_W     = 64;  // magnitude of a sum, always below 2^64
  localparam int unsigned QUO_W     = 32;  // quotient bits produced by the divider chain
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_W     = 64;
  localparam int unsigned ADDR_W    = 6;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam logic [REG_W-1:0] REG_ZERO = '0;

  // Per-word control that rides alongside the divider lanes.
  typedef struct packed {
    logic [2:0] neg;   // quotient sign per lane
    logic [2:0] ovf;   // quotient is 2^32 or more per lane
    logic       wz;    // homogeneous w is zero
  } side_t;

  // Identity element 1.0 for a given number of fraction bits.
  function automatic logic [COORD_W-1:0] fx_one(input int unsigned frac);
    fx_one = COORD_W'(1) << frac;
  endfunction

endpackage

>>> hw/rtl/vtpd_mac.sv
// Matrix multiply front end: products, sums, sign split and divider set-up.
module vtpd_mac #(
  parameter int unsigned FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic [vtpd_pkg::NUM_REGS-1:0][vtpd_pkg::REG_W-1:0] mat_i,
  input  logic                                         v_i,
  output logic                                         ready_o,
  input  logic signed [vtpd_pkg::COORD_W-1:0]          pos_x_i,
  input  logic signed [vtpd_pkg::COORD_W-1:0]          pos_y_i,
  input  logic signed [vtpd_pkg::COORD_W-1:0]          pos_z_i,
  output logic                                         v_o,
  input  logic                                         ready_i,
  output logic [vtpd_pkg::MAG_W-1:0]                   d_o,
  output logic [2:0][vtpd_pkg::MAG_W-1:0]              rem_o,
  output logic [2:0][vtpd_pkg::QUO_W-1:0]              nlow_o,
  output vtpd_pkg::side_t                              side_o
);

  localparam int unsigned SW = vtpd_pkg::SUM_W;
  localparam int unsigned MW = vtpd_pkg::MAG_W;
  localparam int unsigned CW = vtpd_pkg::COORD_W;
  localparam int unsigned QW = vtpd_pkg::QUO_W;
  localparam int unsigned NUM_W = MW + FRAC_BITS;

  logic signed [CW-1:0] pos [3];
  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  logic signed [vtpd_pkg::PROD_W-1:0] prod_d [4][3];
  logic signed [vtpd_pkg::PROD_W-1:0] prod_q [4][3];
  logic signed [SW-1:0]               tr_d [4];
  logic signed [SW-1:0]               tr_q [4];
  logic signed [SW-1:0]               t_d  [4];
  logic signed [SW-1:0]               t_q  [4];
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  for (genvar c = 0; c < 4; c++) begin : g_col
    logic signed [CW-1:0] trans;
    assign trans = mat_i[6 + c/2][CW*(c%2) +: CW];
    assign tr_d[c] = SW'(trans) <<< FRAC_BITS;
    for (genvar r = 0; r < 3; r++) begin : g_row
      logic signed [CW-1:0] elem;
      assign elem = mat_i[2*r + c/2][CW*(c%2) +: CW];
      assign prod_d[c][r] = pos[r] * elem;
    end
    assign t_d[c] = SW'(prod_q[c][0]) + SW'(prod_q[c][1]) + SW'(prod_q[c][2]) + tr_q[c];
  end

  // stage 1: products, stage 2: sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= v_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      prod_q <= prod_d;
      tr_q   <= tr_d;
    end
    if (rdy2) t_q <= t_d;
  end

  // stage 3: magnitudes, scaled numerators, overflow pre-check
  logic [MW-1:0]          mag [4];
  logic [MW-1:0]          rem_d [3];
  logic [QW-1:0]          nlow_d [3];
  vtpd_pkg::side_t        side_d;

  always_comb begin
    logic signed [SW-1:0] a;
    logic [NUM_W-1:0]     num;
    logic [MW-1:0]        hi;
    for (int c = 0; c < 4; c++) begin
      a      = t_q[c][SW-1] ? -t_q[c] : t_q[c];
      mag[c] = a[MW-1:0];
    end
    for (int c = 0; c < 3; c++) begin
      num          = {mag[c], {FRAC_BITS{1'b0}}};
      hi           = MW'(num[NUM_W-1:QW]);
      rem_d[c]     = hi;
      nlow_d[c]    = num[QW-1:0];
      side_d.ovf[c] = hi >= mag[3];
      side_d.neg[c] = t_q[c][SW-1] ^ t_q[3][SW-1];
    end
    side_d.wz = (t_q[3] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (rdy3) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      d_o    <= mag[3];
      side_o <= side_d;
      for (int c = 0; c < 3; c++) begin
        rem_o[c]  <= rem_d[c];
        nlow_o[c] <= nlow_d[c];
      end
    end
  end

  assign v_o = v3_q;

endmodule

>>> hw/rtl/vtpd_div_cell.sv
// One restoring-division step for three lanes sharing a divisor.
module vtpd_div_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               v_i,
  output logic                               ready_o,
  input  logic [vtpd_pkg::MAG_W-1:0]         d_i,
  input  logic [2:0][vtpd_pkg::MAG_W-1:0]    rem_i,
  input  logic [2:0][vtpd_pkg::QUO_W-1:0]    nlow_i,
  input  logic [2:0][vtpd_pkg::QUO_W-1:0]    q_i,
  input  vtpd_pkg::side_t                    side_i,
  output logic                               v_o,
  input  logic                               ready_i,
  output logic [vtpd_pkg::MAG_W-1:0]         d_o,
  output logic [2:0][vtpd_pkg::MAG_W-1:0]    rem_o,
  output logic [2:0][vtpd_pkg::QUO_W-1:0]    nlow_o,
  output logic [2:0][vtpd_pkg::QUO_W-1:0]    q_o,
  output vtpd_pkg::side_t                    side_o
);

  localparam int unsigned MW = vtpd_pkg::MAG_W;
  localparam int unsigned QW = vtpd_pkg::QUO_W;

  logic                  v_q;
  logic [2:0][MW-1:0]    rem_d;
  logic [2:0][QW-1:0]    nlow_d;
  logic [2:0][QW-1:0]    q_d;

  assign ready_o = !v_q || ready_i;

  always_comb begin
    logic [MW:0] trial;
    logic [MW:0] diff;
    logic        ge;
    for (int l = 0; l < 3; l++) begin
      trial     = {rem_i[l], nlow_i[l][QW-1]};
      diff      = trial - {1'b0, d_i};
      ge        = trial >= {1'b0, d_i};
      rem_d[l]  = ge ? diff[MW-1:0] : trial[MW-1:0];
      nlow_d[l] = {nlow_i[l][QW-2:0], 1'b0};
      q_d[l]    = {q_i[l][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (ready_o) v_q <= v_i;
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      d_o    <= d_i;
      rem_o  <= rem_d;
      nlow_o <= nlow_d;
      q_o    <= q_d;
      side_o <= side_i;
    end
  end

  assign v_o = v_q;

endmodule

>>> hw/rtl/vtpd_out.sv
// Output register: sign, saturation and zero-w handling.
module vtpd_out (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               v_i,
  output logic                               ready_o,
  input  logic [2:0][vtpd_pkg::QUO_W-1:0]    q_i,
  input  vtpd_pkg::side_t                    side_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [vtpd_pkg::COORD_W-1:0] proj_x_o,
  output logic signed [vtpd_pkg::COORD_W-1:0] proj_y_o,
  output logic signed [vtpd_pkg::COORD_W-1:0] proj_z_o,
  output logic                               w_zero_o,
  output logic                               saturated_o
);

  localparam int unsigned CW = vtpd_pkg::COORD_W;
  localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] NEG_MIN = {1'b1, {(CW-1){1'b0}}};

  logic              v_q;
  logic [2:0][CW-1:0] res_d;
  logic [2:0][CW-1:0] res_q;
  logic              sat_d, sat_q, wz_q;

  assign ready_o = !v_q || !out_stall_i;

  always_comb begin
    logic [CW-1:0] lim;
    logic          clip;
    sat_d = 1'b0;
    for (int l = 0; l < 3; l++) begin
      lim  = side_i.neg[l] ? NEG_MIN : POS_MAX;
      clip = side_i.ovf[l] || (q_i[l] > lim);
      if (side_i.wz) begin
        res_d[l] = '0;
      end else if (clip) begin
        res_d[l] = lim;
        sat_d    = 1'b1;
      end else begin
        res_d[l] = side_i.neg[l] ? -q_i[l] : q_i[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (ready_o) v_q <= v_i;
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      res_q <= res_d;
      sat_q <= sat_d;
      wz_q  <= side_i.wz;
    end
  end

  assign out_valid_o = v_q;
  assign proj_x_o    = res_q[0];
  assign proj_y_o    = res_q[1];
  assign proj_z_o    = res_q[2];
  assign w_zero_o    = wz_q;
  assign saturated_o = sat_q;

endmodule

>>> hw/rtl/vertex_transform_persp_divide_top.sv
// Top level: 4x4 homogeneous vertex transform with perspective divide.
// Usage
//   Input channel: in_valid_i / in_stall_o carry one point (pos_x/y/z, Q16.16
//   by default) per word. Output channel: out_valid_o / out_stall_i carry the
//   projected point, the w_zero flag and the saturated flag.
//   The 4x4 matrix sits in eight 64-bit APB registers at byte address 8*i;
//   write them only while no word is in flight.
// Pipeline: three multiply/sum/set-up stages, 32 division cells and one output
//   register lie between acceptance and out_valid_o.
// Throughput: one word per cycle while out_stall_i is low, set by the row of 32
//   division cells, each producing one quotient bit for all three lanes per clock.
// Stall: every stage holds its word while the next one is full and stalled;
//   empty stages still fill, so the input keeps being taken until the whole
//   chain is occupied. in_stall_o follows that ready chain.
// Reset: rst_ni clears all stage valids and loads the identity matrix; no
//   clearing pass is needed.
module vertex_transform_persp_divide_top #(
  parameter int unsigned FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // APB configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vtpd_pkg::ADDR_W-1:0]         paddr,
  input  logic [vtpd_pkg::REG_W-1:0]          pwdata,
  output logic [vtpd_pkg::REG_W-1:0]          prdata,
  output logic                                pready,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [vtpd_pkg::COORD_W-1:0] pos_x_i,
  input  logic signed [vtpd_pkg::COORD_W-1:0] pos_y_i,
  input  logic signed [vtpd_pkg::COORD_W-1:0] pos_z_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [vtpd_pkg::COORD_W-1:0] proj_x_o,
  output logic signed [vtpd_pkg::COORD_W-1:0] proj_y_o,
  output logic signed [vtpd_pkg::COORD_W-1:0] proj_z_o,
  output logic                                w_zero_o,
  output logic                                saturated_o
);

  localparam int unsigned NR = vtpd_pkg::NUM_REGS;
  localparam int unsigned RW = vtpd_pkg::REG_W;
  localparam int unsigned MW = vtpd_pkg::MAG_W;
  localparam int unsigned QW = vtpd_pkg::QUO_W;
  localparam int unsigned CW = vtpd_pkg::COORD_W;
  localparam logic [CW-1:0] ONE  = vtpd_pkg::fx_one(FRAC_BITS);
  localparam logic [CW-1:0] ZERO = '0;

  // Matrix registers; reset to identity.
  logic [NR-1:0][RW-1:0] mat_q;
  logic [2:0]            widx;

  assign widx   = paddr[vtpd_pkg::ADDR_W-1:3];
  assign pready = 1'b1;
  assign prdata = mat_q[widx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[0] <= {ZERO, ONE};
      mat_q[1] <= vtpd_pkg::REG_ZERO;
      mat_q[2] <= {ONE, ZERO};
      mat_q[3] <= vtpd_pkg::REG_ZERO;
      mat_q[4] <= vtpd_pkg::REG_ZERO;
      mat_q[5] <= {ZERO, ONE};
      mat_q[6] <= vtpd_pkg::REG_ZERO;
      mat_q[7] <= {ONE, ZERO};
    end else if (psel && penable && pwrite && pready) begin
      mat_q[widx] <= pwdata;
    end
  end

  // Chain wiring: index 0 is the front end output, QW the last cell output.
  logic                 cv    [QW+1];
  logic                 crdy  [QW+1];
  logic [MW-1:0]        cd    [QW+1];
  logic [2:0][MW-1:0]   crem  [QW+1];
  logic [2:0][QW-1:0]   cnlow [QW+1];
  logic [2:0][QW-1:0]   cq    [QW+1];
  vtpd_pkg::side_t      cside [QW+1];
  logic                 mac_rdy;

  assign in_stall_o = !mac_rdy;
  assign cq[0]      = '0;

  vtpd_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mat_i   (mat_q),
    .v_i     (in_valid_i),
    .ready_o (mac_rdy),
    .pos_x_i (pos_x_i),
    .pos_y_i (pos_y_i),
    .pos_z_i (pos_z_i),
    .v_o     (cv[0]),
    .ready_i (crdy[0]),
    .d_o     (cd[0]),
    .rem_o   (crem[0]),
    .nlow_o  (cnlow[0]),
    .side_o  (cside[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_cell
    vtpd_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .v_i     (cv[k]),
      .ready_o (crdy[k]),
      .d_i     (cd[k]),
      .rem_i   (crem[k]),
      .nlow_i  (cnlow[k]),
      .q_i     (cq[k]),
      .side_i  (cside[k]),
      .v_o     (cv[k+1]),
      .ready_i (crdy[k+1]),
      .d_o     (cd[k+1]),
      .rem_o   (crem[k+1]),
      .nlow_o  (cnlow[k+1]),
      .q_o     (cq[k+1]),
      .side_o  (cside[k+1])
    );
  end

  vtpd_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .v_i         (cv[QW]),
    .ready_o     (crdy[QW]),
    .q_i         (cq[QW]),
    .side_i      (cside[QW]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .proj_x_o    (proj_x_o),
    .proj_y_o    (proj_y_o),
    .proj_z_o    (proj_z_o),
    .w_zero_o    (w_zero_o),
    .saturated_o (saturated_o)
  );

  // Zero w gives zero coordinates and no saturation.
  a_wz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && w_zero_o |-> proj_x_o == '0 && proj_y_o == '0 && proj_z_o == '0
                                && !saturated_o)
    else $error("w_zero word with non-zero payload");

  // A free-running receiver never backs up the input.
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  // A saturated word with only x non-zero must have x at one of the two limits.
  a_sat_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o && proj_x_o != '0 && proj_y_o == '0 && proj_z_o == '0
    |-> proj_x_o == {1'b0, {(CW-1){1'b1}}} || proj_x_o == {1'b1, {(CW-1){1'b0}}})
    else $error("saturated word with x off the limits");

endmodule
